@@ rtl/csvt_pkg.sv @@
`timescale 1ns / 1ps
// csvt_pkg: shared types and character codes for the CSV byte tokenizer.
// No dependencies; imported by every module of the block.
package csvt_pkg;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam int TDATA_W = 80;
    localparam int TUSER_W = 3;

    typedef enum logic [2:0] {
        Q_OUTSIDE = 3'b001,
        Q_INSIDE  = 3'b010,
        Q_PENDING = 3'b100
    } t_quote_state;

    // lexer events for one byte
    typedef struct packed {
        logic emit;
        logic close_cell;
        logic close_row;
        logic cell_has;     // cell holds content bytes after this byte
    } t_lex_ev;

    // row bookkeeping result for one byte
    typedef struct packed {
        logic        cell_end;
        logic        row_end;
        logic        row_is_header;
        logic [15:0] row_columns;
        logic [15:0] widest_row;
        logic        rows_ragged;
        logic [31:0] row_number;
    } t_trk_res;

endpackage

@@ rtl/csvt_lexer.sv @@
`timescale 1ns / 1ps
// csvt_lexer: quote state machine and CR/LF handling for one byte per request.
// Depends on csvt_pkg.
module csvt_lexer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_fin,
    output csvt_pkg::t_lex_ev o_ev
);
    import csvt_pkg::*;

    t_quote_state r_quote, n_quote;
    logic         r_skip, n_skip;
    logic         r_has, n_has;
    logic         emit, close_cell, close_row, go_out;

    always_comb begin
        n_quote    = r_quote;
        n_skip     = 1'b0;
        n_has      = r_has;
        emit       = 1'b0;
        close_cell = 1'b0;
        close_row  = 1'b0;
        go_out     = 1'b0;
        if (!(r_skip && i_byte == CH_LF)) begin
            unique case (r_quote)
                Q_PENDING: begin
                    if (i_byte == CH_QUOTE) begin
                        n_quote = Q_INSIDE;
                        emit    = 1'b1;
                    end else begin
                        n_quote = Q_OUTSIDE;
                        go_out  = 1'b1;
                    end
                end
                Q_INSIDE: begin
                    if (i_byte == CH_QUOTE) begin
                        n_quote = Q_PENDING;
                    end else begin
                        emit = 1'b1;
                    end
                end
                default: go_out = 1'b1;
            endcase
            if (go_out) begin
                priority if (i_byte == CH_QUOTE) begin
                    n_quote = Q_INSIDE;
                end else if (i_byte == CH_COMMA) begin
                    close_cell = 1'b1;
                end else if (i_byte == CH_CR || i_byte == CH_LF) begin
                    close_cell = 1'b1;
                    close_row  = 1'b1;
                    n_skip     = (i_byte == CH_CR);
                end else begin
                    emit = 1'b1;
                end
            end
            if (emit) begin
                n_has = 1'b1;
            end
            if (close_cell) begin
                n_has = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= Q_OUTSIDE;
            r_skip  <= 1'b0;
            r_has   <= 1'b0;
        end else if (i_accept) begin
            if (i_fin) begin
                r_quote <= Q_OUTSIDE;
                r_skip  <= 1'b0;
                r_has   <= 1'b0;
            end else begin
                r_quote <= n_quote;
                r_skip  <= n_skip;
                r_has   <= n_has;
            end
        end
    end

    assign o_ev.emit       = emit;
    assign o_ev.close_cell = close_cell;
    assign o_ev.close_row  = close_row;
    assign o_ev.cell_has   = n_has;

    // a skipped LF only ever follows a CR, which leaves no open cell
    a_skip_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> !r_has && r_quote == Q_OUTSIDE)
        else $error("pending LF skip with open cell or quoting");

endmodule

@@ rtl/csvt_tracker.sv @@
`timescale 1ns / 1ps
// csvt_tracker: column and row counters, final flush, data-row width metrics.
// Depends on csvt_pkg; fed by csvt_lexer events.
module csvt_tracker #(
    parameter int unsigned MAX_COLUMNS = 65535
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_fin,
    input  logic               i_hdr_mode,
    input  csvt_pkg::t_lex_ev  i_ev,
    output csvt_pkg::t_trk_res o_res
);
    import csvt_pkg::*;

    localparam logic [15:0] COL_CAP = (MAX_COLUMNS < 32'd65535) ?
                                      MAX_COLUMNS[15:0] : 16'hFFFF;

    function automatic logic [15:0] col_inc(input logic [15:0] c);
        col_inc = (c >= COL_CAP) ? COL_CAP : c + 16'd1;
    endfunction

    logic [15:0] r_col, n_col;
    logic [31:0] r_row, n_row;
    logic [15:0] r_first, n_first;
    logic        r_seen, n_seen;
    logic [15:0] r_max, n_max;
    logic        r_rag, n_rag;

    logic [15:0] col_a, col_after, width;
    logic        flush, row_close, hdr;

    always_comb begin
        col_a     = i_ev.close_cell ? col_inc(r_col) : r_col;
        col_after = i_ev.close_row ? 16'd0 : col_a;
        flush     = i_fin && (i_ev.cell_has || col_after != 16'd0);
        row_close = i_ev.close_row || flush;
        width     = i_ev.close_row ? col_a : col_inc(col_after);
        hdr       = i_hdr_mode && (r_row == 32'd0);

        n_max   = r_max;
        n_seen  = r_seen;
        n_first = r_first;
        n_rag   = r_rag;
        if (row_close && !hdr) begin
            if (width > r_max) begin
                n_max = width;
            end
            if (!r_seen) begin
                n_seen  = 1'b1;
                n_first = width;
            end else if (width != r_first) begin
                n_rag = 1'b1;
            end
        end
        n_row = (row_close && r_row != 32'hFFFF_FFFF) ? r_row + 32'd1 : r_row;
        n_col = row_close ? 16'd0 : col_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_fin)) begin
            r_col   <= '0;
            r_row   <= '0;
            r_first <= '0;
            r_seen  <= 1'b0;
            r_max   <= '0;
            r_rag   <= 1'b0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_first <= n_first;
            r_seen  <= n_seen;
            r_max   <= n_max;
            r_rag   <= n_rag;
        end
    end

    assign o_res.cell_end      = i_ev.close_cell || flush;
    assign o_res.row_end       = row_close;
    assign o_res.row_is_header = row_close && hdr;
    assign o_res.row_columns   = row_close ? width : 16'd0;
    assign o_res.widest_row    = n_max;
    assign o_res.rows_ragged   = n_rag;
    assign o_res.row_number    = row_close ? r_row : 32'd0;

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_fin |=> r_col == 16'd0 && r_row == 32'd0 && !r_seen)
        else $error("state not cleared after final byte");

    a_col_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_CAP && r_max <= COL_CAP)
        else $error("column count beyond cap");

    a_rag_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rag |-> r_seen)
        else $error("ragged flag without a data row");

endmodule

@@ rtl/csv_byte_tokenizer_top.sv @@
`timescale 1ns / 1ps
// csv_byte_tokenizer_top: RFC 4180 CSV tokenizer, one byte per request.
// Depends on csvt_pkg, csvt_lexer and csvt_tracker.
//
// Usage:
//   Input stream s_axis: tdata carries one file byte, tlast marks the final
//   byte of a file; that request closes any open row and then returns all
//   parsing state to its start, so the next byte begins a new file.
//   Output stream m_axis: exactly one result per input byte. tlast flags a
//   closed row; tuser carries the byte-valid, cell-end and header flags.
//   Configuration: i_cfg_we writes i_cfg_wdata into the header-mode bit;
//   write only while no request is in flight.
// Timing:
//   The result appears in the cycle after a request is accepted. The single
//   result register refills in the same cycle it is drained, so one byte per
//   cycle is sustained while m_axis_tready stays high.
// Reset: synchronous, active low; clears parser state, the result valid flag
//   and the header-mode bit.
// Stall: with a result held and m_axis_tready low, s_axis_tready drops and
//   the held result stays unchanged until taken.
module csv_byte_tokenizer_top #(
    parameter int unsigned MAX_COLUMNS = 65535
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tlast,  // final_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] cell_byte, [23:8] row_columns, [39:24] widest_row,
    // [40] rows_ragged, [72:41] row_number, [79:73] zero
    output logic [csvt_pkg::TDATA_W-1:0]  m_axis_tdata,
    // [0] byte_valid, [1] cell_end, [2] row_is_header
    output logic [csvt_pkg::TUSER_W-1:0]  m_axis_tuser,
    output logic                          m_axis_tlast   // row_end
);
    import csvt_pkg::*;

    logic     r_hdr_mode;
    logic     accept;
    t_lex_ev  ev;
    t_trk_res res;

    logic        r_valid;
    logic        r_byte_valid;
    logic [7:0]  r_cell_byte;
    t_trk_res    r_res;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_hdr_mode <= i_cfg_wdata;
        end
    end

    csvt_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_fin    (s_axis_tlast),
        .o_ev     (ev)
    );

    csvt_tracker #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_tracker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_fin      (s_axis_tlast),
        .i_hdr_mode (r_hdr_mode),
        .i_ev       (ev),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte_valid <= ev.emit;
            r_cell_byte  <= ev.emit ? s_axis_tdata : 8'd0;
            r_res        <= res;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_res.row_number, r_res.rows_ragged,
                            r_res.widest_row, r_res.row_columns, r_cell_byte};
    assign m_axis_tuser  = {r_res.row_is_header, r_res.cell_end, r_byte_valid};
    assign m_axis_tlast  = r_res.row_end;

    a_row_closes_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.row_end |-> r_res.cell_end && r_res.row_columns != 16'd0)
        else $error("row closed without closing a cell");

    a_widest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_res.row_end && !r_res.row_is_header
            |-> r_res.widest_row >= r_res.row_columns)
        else $error("widest row below a data row width");

endmodule

@@ tb/tb_csv_byte_tokenizer_top.sv @@
`timescale 1ns / 1ps
// tb_csv_byte_tokenizer_top: self-checking bench for csv_byte_tokenizer_top.
// Drives CSV byte streams with random stalls and checks every result against a
// tokenizer model kept in the bench. Depends on csvt_pkg and the RTL top.
module tb_csv_byte_tokenizer_top;
    import csvt_pkg::*;

    localparam int unsigned MAX_COLUMNS = 65535;
    localparam logic [15:0] COL_CAP     = (MAX_COLUMNS < 65535) ? MAX_COLUMNS[15:0] : 16'hFFFF;
    localparam int          LIMIT       = 1000000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic                  i_cfg_wdata   = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = 8'h00;
    logic                  s_axis_tlast  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]    m_axis_tdata;
    logic [TUSER_W-1:0]    m_axis_tuser;
    logic                  m_axis_tlast;

    csv_byte_tokenizer_top #(.MAX_COLUMNS(MAX_COLUMNS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct packed {
        logic        byte_valid;
        logic [7:0]  cell_byte;
        logic        cell_end;
        logic        row_end;
        logic        row_is_header;
        logic [15:0] row_columns;
        logic [15:0] widest_row;
        logic        rows_ragged;
        logic [31:0] row_number;
    } t_tok_res;

    // tokenizer model state
    logic         hdr_mode;
    t_quote_state qstate;
    logic         skip_lf;
    logic         cell_busy;
    logic [15:0]  col_count;
    logic [31:0]  row_idx;
    logic [15:0]  first_width;
    logic         data_row_seen;
    logic [15:0]  widest;
    logic         ragged;

    t_tok_res     pending_tokens[$];
    logic [7:0]   file_bytes[$];
    int           err_count   = 0;
    int           bytes_sent  = 0;
    int           idle_pct    = 0;
    int           rx_hold     = 0;
    int           cycle_count = 0;

    function automatic void clear_parser();
        qstate        = Q_OUTSIDE;
        skip_lf       = 1'b0;
        cell_busy     = 1'b0;
        col_count     = '0;
        row_idx       = '0;
        first_width   = '0;
        data_row_seen = 1'b0;
        widest        = '0;
        ragged        = 1'b0;
    endfunction

    function automatic void add_file_byte(logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void close_cell_model(inout t_tok_res r);
        if (col_count != COL_CAP) col_count++;
        cell_busy  = 1'b0;
        r.cell_end = 1'b1;
    endfunction

    function automatic void close_row_model(inout t_tok_res r);
        logic is_hdr;
        is_hdr          = hdr_mode && (row_idx == 0);
        r.row_end       = 1'b1;
        r.row_is_header = is_hdr;
        r.row_columns   = col_count;
        r.row_number    = row_idx;
        if (!is_hdr) begin
            if (col_count > widest) widest = col_count;
            if (!data_row_seen) begin
                data_row_seen = 1'b1;
                first_width   = col_count;
            end else if (col_count != first_width) begin
                ragged = 1'b1;
            end
        end
        if (row_idx != 32'hFFFF_FFFF) row_idx++;
        col_count = '0;
        cell_busy = 1'b0;
    endfunction

    function automatic t_tok_res tokenize_byte(logic [7:0] b, logic fin);
        t_tok_res r;
        logic     plain;
        r = '0;
        if (skip_lf && b == CH_LF) begin
            skip_lf = 1'b0;
        end else begin
            skip_lf = 1'b0;
            plain   = 1'b1;
            if (qstate == Q_PENDING) begin
                if (b == CH_QUOTE) begin
                    qstate       = Q_INSIDE;
                    r.byte_valid = 1'b1;
                    r.cell_byte  = b;
                    cell_busy    = 1'b1;
                    plain        = 1'b0;
                end else begin
                    qstate = Q_OUTSIDE;
                end
            end else if (qstate == Q_INSIDE) begin
                plain = 1'b0;
                if (b == CH_QUOTE) begin
                    qstate = Q_PENDING;
                end else begin
                    r.byte_valid = 1'b1;
                    r.cell_byte  = b;
                    cell_busy    = 1'b1;
                end
            end
            if (plain) begin
                case (b)
                    CH_QUOTE: qstate = Q_INSIDE;
                    CH_COMMA: close_cell_model(r);
                    CH_CR, CH_LF: begin
                        close_cell_model(r);
                        close_row_model(r);
                        skip_lf = (b == CH_CR);
                    end
                    default: begin
                        r.byte_valid = 1'b1;
                        r.cell_byte  = b;
                        cell_busy    = 1'b1;
                    end
                endcase
            end
        end
        if (fin && (cell_busy || col_count != 0)) begin
            close_cell_model(r);
            close_row_model(r);
        end
        r.widest_row  = widest;
        r.rows_ragged = ragged;
        if (fin) clear_parser();
        return r;
    endfunction

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > LIMIT) begin
                $display("[csv_byte_tokenizer_top] ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls plus an optional long hold-off
    initial begin : rx_side
        int stall;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct / 2) begin
                stall = $urandom_range(1, 12) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
        err_count++;
        $display("%0t %s: expected %0h, got %0h", $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_tok_res want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_tokens.size() == 0) begin
                report_mismatch("unexpected result", 0, m_axis_tdata[7:0]);
            end else begin
                want = pending_tokens.pop_front();
                if (m_axis_tuser[0] !== want.byte_valid)
                    report_mismatch("byte_valid", want.byte_valid, m_axis_tuser[0]);
                if (m_axis_tdata[7:0] !== want.cell_byte)
                    report_mismatch("cell_byte", want.cell_byte, m_axis_tdata[7:0]);
                if (m_axis_tuser[1] !== want.cell_end)
                    report_mismatch("cell_end", want.cell_end, m_axis_tuser[1]);
                if (m_axis_tlast !== want.row_end)
                    report_mismatch("row_end", want.row_end, m_axis_tlast);
                if (m_axis_tuser[2] !== want.row_is_header)
                    report_mismatch("row_is_header", want.row_is_header, m_axis_tuser[2]);
                if (m_axis_tdata[23:8] !== want.row_columns)
                    report_mismatch("row_columns", want.row_columns, m_axis_tdata[23:8]);
                if (m_axis_tdata[39:24] !== want.widest_row)
                    report_mismatch("widest_row", want.widest_row, m_axis_tdata[39:24]);
                if (m_axis_tdata[40] !== want.rows_ragged)
                    report_mismatch("rows_ragged", want.rows_ragged, m_axis_tdata[40]);
                if (m_axis_tdata[72:41] !== want.row_number)
                    report_mismatch("row_number", want.row_number, m_axis_tdata[72:41]);
                if (m_axis_tdata[79:73] !== 7'd0)
                    report_mismatch("tdata pad", 0, m_axis_tdata[79:73]);
            end
        end
    end

    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_tokens.insert(pending_tokens.size(), tokenize_byte(b, fin));
        bytes_sent++;
    endtask

    task automatic send_text(string s, bit fin_last);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], fin_last && (i == s.len() - 1));
    endtask

    task automatic send_file(bit with_final);
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], with_final && (i == file_bytes.size() - 1));
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_header_mode(logic v);
        wait_all_results();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        hdr_mode = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // well-formed CSV with random content; some rows uneven, some files cut short
    task automatic build_csv(int n_rows, int n_cols, bit uneven);
        int   cells;
        int   len;
        logic [7:0] b;
        file_bytes.delete();
        for (int r = 0; r < n_rows; r++) begin
            cells = (uneven && $urandom_range(0, 3) == 0) ? $urandom_range(1, n_cols + 2) : n_cols;
            for (int c = 0; c < cells; c++) begin
                if (c != 0) add_file_byte(CH_COMMA);
                len = $urandom_range(0, 6);
                if ($urandom_range(0, 2) == 0) begin
                    add_file_byte(CH_QUOTE);
                    repeat (len) begin
                        b = 8'($urandom_range(0, 255));
                        if ($urandom_range(0, 5) == 0) b = CH_QUOTE;
                        add_file_byte(b);
                        if (b == CH_QUOTE) add_file_byte(CH_QUOTE);
                    end
                    add_file_byte(CH_QUOTE);
                end else begin
                    repeat (len) begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF);
                        add_file_byte(b);
                    end
                end
            end
            if (r < n_rows - 1 || $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 2))
                    0: add_file_byte(CH_LF);
                    1: add_file_byte(CH_CR);
                    default: begin
                        add_file_byte(CH_CR);
                        add_file_byte(CH_LF);
                    end
                endcase
            end
        end
        if (file_bytes.size() == 0) add_file_byte(8'h41);
        if ($urandom_range(0, 9) == 0)
            while (file_bytes.size() > 1 && $urandom_range(0, 3) != 0) void'(file_bytes.pop_back());
    endtask

    task automatic build_noise();
        file_bytes.delete();
        repeat ($urandom_range(1, 20)) begin
            case ($urandom_range(0, 5))
                0: add_file_byte(CH_QUOTE);
                1: add_file_byte(CH_COMMA);
                2: add_file_byte(CH_CR);
                3: add_file_byte(CH_LF);
                default: add_file_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic test_directed_cases();
        idle_pct = 20;
        send_text("a,\"b\"\"c\"\015\n", 1'b0);   // doubled quote, CR then skipped LF
        send_text("\"x\"y\n", 1'b0);             // pending quote left by a plain byte
        send_text("\n", 1'b0);                   // empty row
        send_byte(8'hFF, 1'b0);
        send_byte(CH_COMMA, 1'b1);               // final comma: two cells
        send_text("\"q", 1'b1);                  // unterminated quoted cell flushed
        send_text("\"z\"", 1'b1);                // quote pending at final
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_output_hold_off();
        write_header_mode(1'b1);
        idle_pct = 0;
        rx_hold  = 150;
        build_csv(4, 3, 1'b0);
        send_file(1'b1);
        build_csv(3, 2, 1'b1);
        send_file(1'b1);
    endtask

    task automatic test_wide_row();
        write_header_mode(1'b0);
        idle_pct = 0;
        repeat (40) send_byte(CH_COMMA, 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_LF, 1'b1);
    endtask

    task automatic test_random_files(int n_items, logic hdr, int pct);
        int target;
        write_header_mode(hdr);
        idle_pct = pct;
        target   = bytes_sent + n_items;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 4) == 0)
                build_noise();
            else
                build_csv($urandom_range(1, 5), $urandom_range(1, 5), $urandom_range(0, 2) == 0);
            send_file($urandom_range(0, 9) != 0);
        end
    endtask

    initial begin
        hdr_mode = 1'b0;
        clear_parser();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_output_hold_off();
        test_wide_row();
        test_random_files(220, 1'b1, 30);
        test_random_files(220, 1'b0, 15);
        test_random_files(200, 1'b1, 45);
        test_random_files(220, 1'b0, 0);

        wait_all_results();
        repeat (5) @(posedge i_clk);
        if (err_count == 0 && pending_tokens.size() == 0)
            $display("[csv_byte_tokenizer_top] OK");
        else
            $display("[csv_byte_tokenizer_top] ERROR");
        $finish;
    end

endmodule
